// ----- rtl/otq_pkg.sv -----
// types and constants shared by the timer queue modules
package otq_pkg;

   localparam int unsigned MaxFire = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [63:0] now_time;
      logic [63:0] expiry_time;
      logic [7:0]  timer_id;
      logic        repeat_req;
      logic [31:0] interval_us;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [7:0]  fired_id;
      logic        last;
      logic        dropped;
      logic        earliest_valid;
      logic [63:0] earliest_expiry;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request beat
      logic do_insert;   // write entry into first free slot
      logic scan_clear;  // begin a scan pass
      logic scan_step;   // examine one slot
      logic fire;        // fire the chosen slot
      logic emit_fire;   // send next fired beat
      logic emit_last;   // this fired beat closes the tick
      logic emit_done;   // send closing beat (insert or quiet tick)
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic scan_end;    // current slot is the last one
      logic found;       // scan found an expired slot
   } sts_type;

endpackage

// ----- rtl/ordered_timer_queue_top.sv -----
// top level of the ordered timer queue
//
//  channel | ports                       | direction | beat marked by
//  --------+-----------------------------+-----------+-------------------
//  request | start, busy, req_data       | in        | start && !busy
//  result  | rsp_strobe, rsp_data        | out       | rsp_strobe
//
// sequence: an insert runs decode, one pass for the earliest expiry and the
// emit state; a tick runs up to 16 search passes (the last one finding no
// expired timer, unless 16 fired), the earliest pass, then one emit per beat;
// each pass scans one slot a cycle; each result beat follows its emit cycle
// reset clears the used bits, the result strobe and the controller; slot contents stay undefined
// results cannot be stalled: each result beat shows for one cycle only
module ordered_timer_queue_top #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  otq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output otq_pkg::rsp_type rsp_data
);

   otq_pkg::cmd_type cmd;
   otq_pkg::sts_type sts;

   // controller: decode, search passes, earliest pass, beat emission
   otq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: slot table, scan registers, fired id buffer, result register
   otq_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/otq_ctrl.sv -----
// sequencing state machine for the timer queue
module otq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  otq_pkg::sts_type  sts,
   output otq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_PICK   = 6'b001000,
      ST_MIN    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] count_ff, count_in;   // timers fired this tick
   logic [4:0] sent_ff, sent_in;     // fired beats sent so far

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sent_in  = sent_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            count_in = '0;
            sent_in  = '0;
            cmd.scan_clear = 1'b1;
            if (sts.is_tick) begin
               state_in = ST_SCAN;
            end else begin
               cmd.do_insert = 1'b1;
               state_in = ST_MIN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.scan_clear = 1'b1;
            if (sts.found) begin
               cmd.fire = 1'b1;
               count_in = count_ff + 5'd1;
               if (count_in == 5'(otq_pkg::MaxFire)) state_in = ST_MIN;
               else state_in = ST_SCAN;
            end else begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            // final pass for the earliest pending expiry
            cmd.scan_step = 1'b1;
            if (sts.scan_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (count_ff == '0) begin
               cmd.emit_done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.emit_fire = 1'b1;
               sent_in = sent_ff + 5'd1;
               if (sent_in == count_ff) begin
                  cmd.emit_last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sent_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sent_ff  <= sent_in;
      end
   end

endmodule

// ----- rtl/otq_dp.sv -----
// slot table, scan comparators and result register for the timer queue
module otq_dp #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  otq_pkg::req_type  req_data,
   input  otq_pkg::cmd_type  cmd,
   output otq_pkg::sts_type  sts,
   output logic              rsp_strobe,
   output otq_pkg::rsp_type  rsp_data
);

   localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned FireW = $clog2(otq_pkg::MaxFire);

   logic [TABLE_DEPTH-1:0] used_ff;
   logic [63:0]            expiry_ff [TABLE_DEPTH];
   logic [7:0]             id_ff     [TABLE_DEPTH];
   logic                   rep_ff    [TABLE_DEPTH];
   logic [31:0]            intv_ff   [TABLE_DEPTH];

   otq_pkg::req_type       req_ff;
   logic [IdxW-1:0]        idx_ff;
   logic                   found_ff;
   logic [IdxW-1:0]        best_ff;
   logic [63:0]            best_exp_ff;
   logic                   any_ff;    // any used slot, for earliest
   logic [63:0]            min_ff;
   logic [TABLE_DEPTH-1:0] picked_ff; // fired this tick
   logic                   drop_ff;
   logic [7:0]             fid_ff [otq_pkg::MaxFire];  // fired ids in firing order
   logic [FireW-1:0]       wr_ff;
   logic [FireW-1:0]       rd_ff;
   logic                   strobe_ff;
   otq_pkg::rsp_type       rsp_ff;

   // first free slot
   logic            free_ok;
   logic [IdxW-1:0] free_idx;
   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // one slot per cycle through the scan
   logic [63:0] cur_exp;
   logic        cur_cand;
   logic        cur_used;
   logic        scan_end;
   assign cur_used = used_ff[idx_ff];
   assign cur_exp  = expiry_ff[idx_ff];
   assign cur_cand = cur_used && !picked_ff[idx_ff] && (cur_exp < req_ff.now_time);
   assign scan_end = (idx_ff == IdxW'(TABLE_DEPTH - 1));

   logic [64:0] rearm_sum;
   assign rearm_sum = {1'b0, req_ff.now_time} + {33'd0, intv_ff[best_ff]};

   // used bits are the only reset state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_fire || cmd.emit_done;
         if (cmd.do_insert && free_ok) begin
            used_ff[free_idx] <= 1'b1;
         end else if (cmd.fire && !rep_ff[best_ff]) begin
            used_ff[best_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         picked_ff <= '0;
         wr_ff     <= '0;
         rd_ff     <= '0;
      end else begin
         if (cmd.do_insert) begin
            drop_ff <= !free_ok;
            if (free_ok) begin
               expiry_ff[free_idx] <= req_ff.expiry_time;
               id_ff[free_idx]     <= req_ff.timer_id;
               rep_ff[free_idx]    <= req_ff.repeat_req;
               intv_ff[free_idx]   <= req_ff.interval_us;
            end
         end else if (cmd.fire) begin
            picked_ff[best_ff] <= 1'b1;
            fid_ff[wr_ff]      <= id_ff[best_ff];
            wr_ff              <= wr_ff + FireW'(1);
            // re-arm at tick time plus interval, saturating
            if (rep_ff[best_ff]) begin
               expiry_ff[best_ff] <= rearm_sum[64] ? '1 : rearm_sum[63:0];
            end
         end
         if (cmd.emit_fire) begin
            rsp_ff.fired    <= 1'b1;
            rsp_ff.fired_id <= fid_ff[rd_ff];
            rsp_ff.last     <= cmd.emit_last;
            rsp_ff.dropped  <= 1'b0;
            rd_ff           <= rd_ff + FireW'(1);
         end else if (cmd.emit_done) begin
            rsp_ff.fired    <= 1'b0;
            rsp_ff.fired_id <= '0;
            rsp_ff.last     <= 1'b1;
            rsp_ff.dropped  <= (req_ff.operation == otq_pkg::OP_INSERT) && drop_ff;
         end
         if (cmd.emit_fire || cmd.emit_done) begin
            rsp_ff.earliest_valid  <= any_ff;
            rsp_ff.earliest_expiry <= any_ff ? min_ff : '0;
         end
      end
   end

   // scan registers: best expired candidate and smallest pending expiry
   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
         min_ff   <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= scan_end ? '0 : idx_ff + IdxW'(1);
         if (cur_cand && (!found_ff || cur_exp < best_exp_ff)) begin
            found_ff    <= 1'b1;
            best_ff     <= idx_ff;
            best_exp_ff <= cur_exp;
         end
         if (cur_used && (!any_ff || cur_exp < min_ff)) begin
            any_ff <= 1'b1;
            min_ff <= cur_exp;
         end
      end
   end

   assign sts.is_tick  = (req_ff.operation == otq_pkg::OP_TICK);
   assign sts.scan_end = scan_end;
   assign sts.found    = found_ff;

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/otq_checker.sv -----
// port-level checks for the ordered timer queue
module otq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input otq_pkg::rsp_type rsp_data,
   input logic             rsp_strobe
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");

   a_no_id_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.fired |-> rsp_data.fired_id == 8'd0)
      else $error("id on quiet beat");

   a_drop_not_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.dropped |-> !rsp_data.fired && rsp_data.last)
      else $error("bad drop beat");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.earliest_valid |-> rsp_data.earliest_expiry == 64'd0)
      else $error("expiry without pending timer");

endmodule

bind ordered_timer_queue_top otq_checker u_otq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);

// ----- tb/tb_ordered_timer_queue_top.sv -----
// testbench for the ordered timer queue: directed and random inserts and ticks checked against a predictor
`timescale 1ns / 100ps

module tb_ordered_timer_queue_top;

   localparam int unsigned Depth = 16;
   localparam int unsigned IdleLimit = 20000;

   // scoreboard: keeps its own copy of the timer table and the expected beats
   class timer_scoreboard;
      bit                 used [Depth];
      bit [63:0]          expiry [Depth];
      bit [7:0]           ident [Depth];
      bit                 rep [Depth];
      bit [31:0]          ival [Depth];
      otq_pkg::rsp_type   pending_beats [$];
      int                 fail_count;

      function void clear();
         foreach (used[i]) used[i] = 0;
         pending_beats.delete();
         fail_count = 0;
      endfunction

      function int unsigned used_count();
         int unsigned n;
         n = 0;
         foreach (used[i]) n += used[i];
         return n;
      endfunction

      // work out the beats for one accepted request
      function void note_request(otq_pkg::req_type r);
         otq_pkg::rsp_type beats [$];
         otq_pkg::rsp_type b;
         bit          picked [Depth];
         bit          placed;
         bit          ev;
         bit [63:0]   ew;
         bit [64:0]   sum;
         int          best;
         int          order [$];
         placed = 0;
         foreach (picked[i]) picked[i] = 0;
         if (r.operation == otq_pkg::OP_INSERT) begin
            for (int i = 0; i < Depth && !placed; i++) begin
               if (!used[i]) begin
                  used[i] = 1;
                  expiry[i] = r.expiry_time;
                  ident[i] = r.timer_id;
                  rep[i] = r.repeat_req;
                  ival[i] = r.interval_us;
                  placed = 1;
               end
            end
            b = '0;
            b.last = 1;
            b.dropped = !placed;
            beats = {beats, b};
         end else begin
            // pick expired entries in expiry order, lower slot on ties
            while (order.size() < otq_pkg::MaxFire) begin
               best = -1;
               for (int i = 0; i < Depth; i++) begin
                  if (used[i] && !picked[i] && expiry[i] < r.now_time) begin
                     if (best < 0 || expiry[i] < expiry[best]) best = i;
                  end
               end
               if (best < 0) break;
               picked[best] = 1;
               order = {order, best};
            end
            foreach (order[j]) begin
               b = '0;
               b.fired = 1;
               b.fired_id = ident[order[j]];
               b.last = (j == order.size() - 1);
               beats = {beats, b};
               if (rep[order[j]]) begin
                  sum = {1'b0, r.now_time} + {33'b0, ival[order[j]]};
                  expiry[order[j]] = sum[64] ? '1 : sum[63:0];
               end else begin
                  used[order[j]] = 0;
               end
            end
            if (order.size() == 0) begin
               b = '0;
               b.last = 1;
               beats = {beats, b};
            end
         end
         ev = 0;
         ew = '0;
         for (int i = 0; i < Depth; i++) begin
            if (used[i] && (!ev || expiry[i] < ew)) begin
               ev = 1;
               ew = expiry[i];
            end
         end
         foreach (beats[k]) begin
            beats[k].earliest_valid = ev;
            beats[k].earliest_expiry = ew;
            pending_beats = {pending_beats, beats[k]};
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         fail_count++;
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      endtask

      // compare one result beat with the oldest expected beat
      task check_result(otq_pkg::rsp_type got);
         otq_pkg::rsp_type w;
         if (pending_beats.size() == 0) begin
            report("unexpected beat", 64'(got.fired_id), 64'd0);
            return;
         end
         w = pending_beats.pop_front();
         if (got.fired !== w.fired) report("fired", 64'(got.fired), 64'(w.fired));
         if (got.fired_id !== w.fired_id)
            report("fired_id", 64'(got.fired_id), 64'(w.fired_id));
         if (got.last !== w.last) report("last", 64'(got.last), 64'(w.last));
         if (got.dropped !== w.dropped)
            report("dropped", 64'(got.dropped), 64'(w.dropped));
         if (got.earliest_valid !== w.earliest_valid)
            report("earliest_valid", 64'(got.earliest_valid), 64'(w.earliest_valid));
         if (got.earliest_expiry !== w.earliest_expiry)
            report("earliest_expiry", got.earliest_expiry, w.earliest_expiry);
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   otq_pkg::req_type req_data;
   logic             rsp_strobe;
   otq_pkg::rsp_type rsp_data;

   timer_scoreboard timers;
   int unsigned     idle_cycles;
   bit              quiet_phase;   // no idling in the last stretch
   bit [63:0]       clock_now;     // running time used by the random ticks

   ordered_timer_queue_top #(.TABLE_DEPTH(Depth)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: check every strobed beat, and watch for stalls
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) timers.check_result(rsp_data);
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("tb_ordered_timer_queue_top NOT OK");
            $finish;
         end
      end
   end

   // present one request beat and hold it until it is taken
   task automatic send_request(otq_pkg::req_type r);
      int unsigned gap;
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      timers.note_request(r);
   endtask

   task automatic send_insert(bit [63:0] exp, bit [7:0] id, bit rp, bit [31:0] iv);
      otq_pkg::req_type r;
      logic [191:0]     rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = rnd[$bits(otq_pkg::req_type)-1:0];
      r.operation = otq_pkg::OP_INSERT;
      r.expiry_time = exp;
      r.timer_id = id;
      r.repeat_req = rp;
      r.interval_us = iv;
      send_request(r);
   endtask

   task automatic send_tick(bit [63:0] t);
      otq_pkg::req_type r;
      logic [191:0]     rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = rnd[$bits(otq_pkg::req_type)-1:0];
      r.operation = otq_pkg::OP_TICK;
      r.now_time = t;
      send_request(r);
   endtask

   // stop requesting, then wait until every expected beat is in
   task automatic drain();
      start <= 1'b0;
      while (timers.pending_beats.size() != 0) @(posedge clock);
      repeat (4 * Depth) @(posedge clock);
   endtask

   initial begin
      bit [63:0] exp;
      timers = new();
      timers.clear();
      quiet_phase = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: quiet tick on empty table, extremes, ties, saturation, full table
      send_tick('1);
      send_insert('0, 8'h00, 1'b0, 32'h0);
      send_insert('1, 8'hff, 1'b1, 32'hffff_ffff);
      send_insert(64'd100, 8'h11, 1'b1, 32'd0);
      send_insert(64'd100, 8'h22, 1'b0, 32'd5);
      send_insert(64'd50, 8'h33, 1'b1, 32'hffff_ffff);
      send_tick(64'd100);   // strictly-before: only the zero and 50 entries fire
      send_tick(64'd101);   // tie at 100 goes lower slot first
      send_tick(64'd101);   // zero-interval entry re-armed at 101 does not fire
      send_tick(64'd102);
      send_tick(64'hffff_ffff_ffff_fff0);   // re-arm saturates
      for (int i = 0; i < Depth + 2; i++)
         send_insert(64'd1000 + i % 3, 8'(8'h40 + i), i[0], 32'd7);
      send_tick('1);       // many fire at once
      send_tick('1);
      drain();

      // random: mostly small times so entries really expire
      clock_now = 64'd0;
      for (int n = 0; n < 130; n++) begin
         if (n == 105) quiet_phase = 1;
         if ($urandom_range(0, 99) < 3) begin
            exp = {$urandom, $urandom};
         end else begin
            exp = clock_now + $urandom_range(0, 400);
         end
         if ($urandom_range(0, 99) < 55 && timers.used_count() < Depth + 1) begin
            send_insert(exp, 8'($urandom), 1'($urandom_range(0, 1)),
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300));
         end else begin
            clock_now += $urandom_range(0, 250);
            if ($urandom_range(0, 39) == 0) send_tick({$urandom, $urandom});
            else send_tick(clock_now);
         end
      end

      drain();
      if (timers.fail_count == 0) begin
         $display("tb_ordered_timer_queue_top OK");
      end else begin
         $display("tb_ordered_timer_queue_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/otq_pkg.sv
rtl/otq_ctrl.sv
rtl/otq_dp.sv
rtl/ordered_timer_queue_top.sv
rtl/otq_checker.sv
tb/tb_ordered_timer_queue_top.sv
